>>> design/blit_command_builder_top_assert.svh
// Assertion macros for the blit command builder top level.
// Used only by blit_command_builder_top.sv; needs aclk and aresetn in scope.
`ifndef BLIT_COMMAND_BUILDER_TOP_ASSERT_SVH
`define BLIT_COMMAND_BUILDER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define BCB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);
`define BCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BCB_ASSERT_IMPL(lbl, ante, cons, msg)
`define BCB_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> design/bcb_pkg.sv
// Shared types, register codes and constants of the blit command builder.
// No dependencies; imported by every module of the block.
package bcb_pkg;

    localparam int COORD_BITS = 12;
    localparam int SCOORD_W   = COORD_BITS + 1;

    typedef enum logic [1:0] {
        KIND_INIT = 2'd0,
        KIND_FILL = 2'd1,
        KIND_COPY = 2'd2
    } kind_t;

    localparam logic [3:0] CFG_FB_BASE      = 4'd0;
    localparam logic [3:0] CFG_LINE_PITCH   = 4'd1;
    localparam logic [3:0] CFG_PIXEL_DEPTH  = 4'd2;
    localparam logic [3:0] CFG_SCREEN_WIDTH = 4'd3;

    localparam logic [3:0] REG_MODE   = 4'd0;
    localparam logic [3:0] REG_CTRL   = 4'd1;
    localparam logic [3:0] REG_FG     = 4'd3;
    localparam logic [3:0] REG_PITCH  = 4'd5;
    localparam logic [3:0] REG_SRC    = 4'd9;
    localparam logic [3:0] REG_DST    = 4'd11;
    localparam logic [3:0] REG_EXTENT = 4'd12;

    localparam logic [31:0] ROP_COPY        = 32'h000c_0000;
    localparam logic [31:0] FIFO_ENABLE     = 32'h0800_0000;
    localparam logic [31:0] SKIP_MAP        = 32'h8000_0000;
    localparam logic [31:0] SRC_IS_FG       = 32'h0000_0008;
    localparam logic [31:0] X_DECREMENT     = 32'h0000_0002;
    localparam logic [31:0] DST_Y_DECREMENT = 32'h0000_0001;
    localparam logic [31:0] SRC_Y_DECREMENT = 32'h0000_0010;
    localparam logic [15:0] DEPTH8_CODE     = 16'h0100;
    localparam logic [15:0] DEPTH16_CODE    = 16'h0200;
    localparam logic [5:0]  DEPTH_8BPP      = 6'd8;
    localparam logic [5:0]  DEPTH_16BPP     = 6'd16;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
    } bcb_word_t;

    // One request's worth of register writes, handed to the output sequencer.
    typedef struct packed {
        logic                  none;
        logic                  status;
        logic [1:0]            last_idx;
        bcb_word_t [3:0]       words;
    } bcb_batch_t;

    function automatic logic [2:0] width_code(input logic [11:0] w);
        logic [2:0] code;
        case (w)
            12'd320:  code = 3'd1;
            12'd640:  code = 3'd2;
            12'd800:  code = 3'd3;
            12'd1024: code = 3'd4;
            12'd1152: code = 3'd5;
            12'd1280: code = 3'd6;
            12'd1600: code = 3'd7;
            default:  code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

>>> design/bcb_addr.sv
// Two-stage framebuffer offset unit: base + y*pitch + x*bytes_per_pixel mod 2^32.
// Uses bcb_pkg; stage enables come from the pipeline control in the top level.
module bcb_addr import bcb_pkg::*; (
    input  logic                aclk,
    input  logic                mul_en,
    input  logic                add_en,
    input  logic [SCOORD_W-1:0] x,
    input  logic [SCOORD_W-1:0] y,
    input  logic                wide_pixel,
    input  logic [15:0]         pitch,
    input  logic [31:0]         base,
    output logic [31:0]         offset
);

    logic [31:0] x_ext;
    logic [31:0] y_ext;
    logic [47:0] prod_full;
    logic [31:0] prod_reg;
    logic [31:0] xb_reg;
    logic [31:0] offset_reg;

    // Coordinates are signed so that an edge of zero minus one wraps like the
    // 32-bit arithmetic it stands for.
    assign x_ext     = {{(32-SCOORD_W){x[SCOORD_W-1]}}, x};
    assign y_ext     = {{(32-SCOORD_W){y[SCOORD_W-1]}}, y};
    assign prod_full = y_ext * pitch;

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= prod_full[31:0];
            xb_reg   <= wide_pixel ? {x_ext[30:0], 1'b0} : x_ext;
        end
        if (add_en) begin
            offset_reg <= base + prod_reg + xb_reg;
        end
    end

    assign offset = offset_reg;

endmodule

>>> design/bcb_emit.sv
// Output sequencer: holds one request's register writes and sends them one per cycle
// while m_ready is high. Uses bcb_pkg for the batch type.
module bcb_emit import bcb_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  bcb_batch_t  in_batch,
    output logic        in_ready,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [3:0]  m_reg_index,
    output logic [31:0] m_reg_value,
    output logic        m_last,
    output logic        m_status
);

    logic            busy_reg, busy_next;
    logic [1:0]      cnt_reg, cnt_next;
    logic [1:0]      last_reg;
    logic            status_reg;
    bcb_word_t [3:0] words_reg;
    logic            at_last;
    logic            load;

    assign at_last  = (cnt_reg == last_reg);
    assign in_ready = !busy_reg || (m_ready && at_last);
    assign load     = in_valid && in_ready;

    always_comb begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (load) begin
            // A request that writes nothing is dropped here.
            busy_next = !in_batch.none;
            cnt_next  = 2'd0;
        end else if (busy_reg && m_ready) begin
            if (at_last) begin
                busy_next = 1'b0;
            end else begin
                cnt_next = cnt_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        if (load) begin
            words_reg  <= in_batch.words;
            last_reg   <= in_batch.last_idx;
            status_reg <= in_batch.status;
        end
    end

    assign m_valid     = busy_reg;
    assign m_reg_index = words_reg[cnt_reg].index;
    assign m_reg_value = words_reg[cnt_reg].value;
    assign m_last      = at_last;
    assign m_status    = status_reg;

endmodule

>>> design/blit_command_builder_top.sv
// Blit command builder top level: turns drawing requests into blitter register writes.
// An accepted item moves through stages 1, 2 and 3 into the output sequencer.
// A new item enters while stage 1 is empty or moves on; the single result channel
// sends one write per cycle while m_ready is high: four for a fill or copy,
// two for an init, one for an unsupported depth.
// Reset (aresetn low, synchronous) empties the pipeline and loads the register defaults.
`include "blit_command_builder_top_assert.svh"
module blit_command_builder_top import bcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [COORD_BITS-1:0] s_dst_min_x,
    input  logic [COORD_BITS-1:0] s_dst_min_y,
    input  logic [COORD_BITS-1:0] s_dst_max_x,
    input  logic [COORD_BITS-1:0] s_dst_max_y,
    input  logic [COORD_BITS-1:0] s_src_min_x,
    input  logic [COORD_BITS-1:0] s_src_min_y,
    input  logic [COORD_BITS-1:0] s_src_max_x,
    input  logic [COORD_BITS-1:0] s_src_max_y,
    input  logic [31:0]           s_fill_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [3:0]            m_reg_index,
    output logic [31:0]           m_reg_value,
    output logic                  m_last,
    output logic                  m_status
);

    typedef struct packed {
        logic [1:0]  kind;
        logic        unsup;
        logic [15:0] flags;
        logic [31:0] ctrl;
        logic [31:0] extent;
        logic [31:0] fill;
    } meta_t;

    logic [31:0] fb_base_reg;
    logic [15:0] line_pitch_reg;
    logic [5:0]  pixel_depth_reg;
    logic [11:0] screen_width_reg;

    logic v1_reg, v2_reg, v3_reg;
    logic adv1, adv2, adv3;
    logic emit_ready;

    meta_t meta1_reg, meta2_reg, meta3_reg;
    meta_t meta_in;
    logic [SCOORD_W-1:0] sx1_reg, sy1_reg, dx1_reg, dy1_reg;
    logic [SCOORD_W-1:0] sx_in, sy_in, dx_in, dy_in;
    logic                forward;
    logic                wide1_reg;
    logic                depth8, depth16;
    logic [15:0]         ext_x, ext_y;
    logic [31:0]         src_off, dst_off;
    bcb_batch_t          batch;

    // Configuration registers; the user must write them only while idle (not enforced).
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fb_base_reg      <= 32'd0;
            line_pitch_reg   <= 16'd0;
            pixel_depth_reg  <= DEPTH_8BPP;
            screen_width_reg <= 12'd640;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_FB_BASE:      fb_base_reg      <= cfg_data;
                CFG_LINE_PITCH:   line_pitch_reg   <= cfg_data[15:0];
                CFG_PIXEL_DEPTH:  pixel_depth_reg  <= cfg_data[5:0];
                CFG_SCREEN_WIDTH: screen_width_reg <= cfg_data[11:0];
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage moves when it is empty or the next one moves.
    assign adv3    = !v3_reg || emit_ready;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1;

    // Stage 1: decode, direction choice and extent.
    assign depth8  = (pixel_depth_reg == DEPTH_8BPP);
    assign depth16 = (pixel_depth_reg == DEPTH_16BPP);
    assign forward = (s_dst_min_y < s_src_min_y) ||
                     ((s_dst_min_y == s_src_min_y) && (s_dst_min_x < s_src_min_x));
    assign ext_x   = 16'({4'd0, s_dst_max_x} - {4'd0, s_dst_min_x});
    assign ext_y   = 16'({4'd0, s_dst_max_y} - {4'd0, s_dst_min_y});

    always_comb begin
        meta_in.kind   = s_kind;
        meta_in.unsup  = !(depth8 || depth16);
        meta_in.flags  = (depth16 ? DEPTH16_CODE : DEPTH8_CODE) |
                         {3'd0, width_code(screen_width_reg), 10'd0};
        meta_in.ctrl   = {16'd0, meta_in.flags} | FIFO_ENABLE | SKIP_MAP | ROP_COPY;
        meta_in.extent = {ext_y, ext_x};
        meta_in.fill   = s_fill_value;
        if ((s_kind == KIND_COPY) && !forward) begin
            // Backward copy starts at the last pixel of both rectangles.
            meta_in.ctrl = meta_in.ctrl | X_DECREMENT | DST_Y_DECREMENT | SRC_Y_DECREMENT;
            sx_in = {1'b0, s_src_max_x} - SCOORD_W'(1);
            sy_in = {1'b0, s_src_max_y} - SCOORD_W'(1);
            dx_in = {1'b0, s_dst_max_x} - SCOORD_W'(1);
            dy_in = {1'b0, s_dst_max_y} - SCOORD_W'(1);
        end else begin
            sx_in = {1'b0, s_src_min_x};
            sy_in = {1'b0, s_src_min_y};
            dx_in = {1'b0, s_dst_min_x};
            dy_in = {1'b0, s_dst_min_y};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
        end
        if (adv1) begin
            meta1_reg <= meta_in;
            sx1_reg   <= sx_in;
            sy1_reg   <= sy_in;
            dx1_reg   <= dx_in;
            dy1_reg   <= dy_in;
            wide1_reg <= depth16;
        end
        if (adv2) meta2_reg <= meta1_reg;
        if (adv3) meta3_reg <= meta2_reg;
    end

    // Stages 2 and 3: multiply by the pitch, then add base and pixel offset.
    bcb_addr u_src_addr (
        .aclk       (aclk),
        .mul_en     (adv2),
        .add_en     (adv3),
        .x          (sx1_reg),
        .y          (sy1_reg),
        .wide_pixel (wide1_reg),
        .pitch      (line_pitch_reg),
        .base       (fb_base_reg),
        .offset     (src_off)
    );

    bcb_addr u_dst_addr (
        .aclk       (aclk),
        .mul_en     (adv2),
        .add_en     (adv3),
        .x          (dx1_reg),
        .y          (dy1_reg),
        .wide_pixel (wide1_reg),
        .pitch      (line_pitch_reg),
        .base       (fb_base_reg),
        .offset     (dst_off)
    );

    // Assemble the register writes of the item leaving stage 3.
    always_comb begin
        batch.none     = 1'b0;
        batch.status   = 1'b0;
        batch.last_idx = 2'd3;
        batch.words[0] = '{index: REG_CTRL,   value: meta3_reg.ctrl};
        batch.words[1] = '{index: REG_SRC,    value: src_off};
        batch.words[2] = '{index: REG_DST,    value: dst_off};
        batch.words[3] = '{index: REG_EXTENT, value: meta3_reg.extent};
        if (meta3_reg.unsup) begin
            batch.status   = 1'b1;
            batch.last_idx = 2'd0;
            batch.words[0] = '{index: REG_MODE, value: 32'd0};
        end else begin
            case (meta3_reg.kind)
                KIND_INIT: begin
                    batch.last_idx = 2'd1;
                    batch.words[0] = '{index: REG_MODE, value: {meta3_reg.flags, 16'd0}};
                    batch.words[1] = '{index: REG_PITCH,
                                       value: {line_pitch_reg, line_pitch_reg}};
                end
                KIND_FILL: begin
                    batch.words[0] = '{index: REG_FG, value: meta3_reg.fill};
                    batch.words[1] = '{index: REG_CTRL,
                                       value: meta3_reg.ctrl | SRC_IS_FG};
                end
                KIND_COPY: ;
                default: batch.none = 1'b1;
            endcase
        end
    end

    bcb_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v3_reg),
        .in_batch    (batch),
        .in_ready    (emit_ready),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_reg_index (m_reg_index),
        .m_reg_value (m_reg_value),
        .m_last      (m_last),
        .m_status    (m_status)
    );

    `BCB_ASSERT_IMPL(a_status_last, m_valid && m_status, m_last, "status item is not last")
    `BCB_ASSERT_IMPL(a_status_zero, m_valid && m_status, (m_reg_index == REG_MODE) && (m_reg_value == 32'd0), "status item carries a write")
    `BCB_ASSERT_IMPL(a_reset_empty, $past(!aresetn), !m_valid && !v1_reg && !v2_reg && !v3_reg, "pipeline not empty after reset")
    `BCB_ASSERT_NEXT(a_stall_hold, v3_reg && !emit_ready, v3_reg, "stage 3 item lost during stall")

endmodule

>>> tb/blit_write_checker.sv
// Checker for the blit command builder: follows configuration and request traffic,
// predicts the register writes of each request and compares them with the m_ channel.
// Depends on bcb_pkg for register codes, request kinds and control flag constants.
module blit_write_checker import bcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [3:0]            cfg_index,
    input  logic [31:0]           cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [1:0]            s_kind,
    input  logic [COORD_BITS-1:0] s_dst_min_x,
    input  logic [COORD_BITS-1:0] s_dst_min_y,
    input  logic [COORD_BITS-1:0] s_dst_max_x,
    input  logic [COORD_BITS-1:0] s_dst_max_y,
    input  logic [COORD_BITS-1:0] s_src_min_x,
    input  logic [COORD_BITS-1:0] s_src_min_y,
    input  logic [COORD_BITS-1:0] s_src_max_x,
    input  logic [COORD_BITS-1:0] s_src_max_y,
    input  logic [31:0]           s_fill_value,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [3:0]            m_reg_index,
    input  logic [31:0]           m_reg_value,
    input  logic                  m_last,
    input  logic                  m_status,
    output int unsigned           errors,
    output int unsigned           outstanding
);

    localparam logic [11:0] RESET_SCREEN_WIDTH = 12'd640;

    typedef struct packed {
        logic [3:0]  index;
        logic [31:0] value;
        logic        last;
        logic        status;
    } blit_write_t;

    blit_write_t expected_writes[$];

    logic [31:0] base_q;
    logic [15:0] pitch_q;
    logic [5:0]  depth_q;
    logic [11:0] width_q;

    initial begin
        errors = 0;
        outstanding = 0;
    end

    function automatic logic [2:0] width_field(input logic [11:0] w);
        case (w)
            12'd320:  return 3'd1;
            12'd640:  return 3'd2;
            12'd800:  return 3'd3;
            12'd1024: return 3'd4;
            12'd1152: return 3'd5;
            12'd1280: return 3'd6;
            12'd1600: return 3'd7;
            default:  return 3'd0;
        endcase
    endfunction

    function automatic logic [31:0] byte_offset(input logic [31:0] x, input logic [31:0] y,
                                                input logic [31:0] bytes);
        return base_q + y * {16'h0, pitch_q} + x * bytes;
    endfunction

    function automatic void expect_write(input logic [3:0] idx, input logic [31:0] val,
                                         input logic last, input logic st);
        blit_write_t w;
        w.index  = idx;
        w.value  = val;
        w.last   = last;
        w.status = st;
        expected_writes.push_back(w);
    endfunction

    function automatic void predict_writes();
        logic [31:0] dx0, dy0, dx1, dy1, sx0, sy0, sx1, sy1;
        logic [31:0] bytes, flags, ctrl, extent;
        dx0 = 32'(s_dst_min_x);
        dy0 = 32'(s_dst_min_y);
        dx1 = 32'(s_dst_max_x);
        dy1 = 32'(s_dst_max_y);
        sx0 = 32'(s_src_min_x);
        sy0 = 32'(s_src_min_y);
        sx1 = 32'(s_src_max_x);
        sy1 = 32'(s_src_max_y);
        bytes = 32'd1;
        flags = 32'(DEPTH8_CODE);
        if (depth_q == DEPTH_16BPP) begin
            bytes = 32'd2;
            flags = 32'(DEPTH16_CODE);
        end
        if (depth_q != DEPTH_8BPP && depth_q != DEPTH_16BPP) begin
            // Unsupported depth answers every request, even an unknown kind, with one status.
            expect_write(REG_MODE, 32'h0, 1'b1, 1'b1);
        end else begin
            // The width code sits in bits 12:10 of the control flags.
            flags = flags | {19'h0, width_field(width_q), 10'h0};
            extent = {dy1[15:0] - dy0[15:0], dx1[15:0] - dx0[15:0]};
            case (s_kind)
                KIND_INIT: begin
                    expect_write(REG_MODE, flags << 16, 1'b0, 1'b0);
                    expect_write(REG_PITCH, {pitch_q, pitch_q}, 1'b1, 1'b0);
                end
                KIND_FILL: begin
                    expect_write(REG_FG, s_fill_value, 1'b0, 1'b0);
                    expect_write(REG_CTRL, flags | FIFO_ENABLE | SRC_IS_FG | SKIP_MAP | ROP_COPY,
                                 1'b0, 1'b0);
                    expect_write(REG_DST, byte_offset(dx0, dy0, bytes), 1'b0, 1'b0);
                    expect_write(REG_EXTENT, extent, 1'b1, 1'b0);
                end
                KIND_COPY: begin
                    ctrl = flags | FIFO_ENABLE | SKIP_MAP | ROP_COPY;
                    if (dy0 < sy0 || (dy0 == sy0 && dx0 < sx0)) begin
                        expect_write(REG_CTRL, ctrl, 1'b0, 1'b0);
                        expect_write(REG_SRC, byte_offset(sx0, sy0, bytes), 1'b0, 1'b0);
                        expect_write(REG_DST, byte_offset(dx0, dy0, bytes), 1'b0, 1'b0);
                    end else begin
                        // Backward copy starts at the last pixel; a zero max edge wraps.
                        ctrl = ctrl | X_DECREMENT | DST_Y_DECREMENT | SRC_Y_DECREMENT;
                        expect_write(REG_CTRL, ctrl, 1'b0, 1'b0);
                        expect_write(REG_SRC, byte_offset(sx1 - 1, sy1 - 1, bytes), 1'b0, 1'b0);
                        expect_write(REG_DST, byte_offset(dx1 - 1, dy1 - 1, bytes), 1'b0, 1'b0);
                    end
                    expect_write(REG_EXTENT, extent, 1'b1, 1'b0);
                end
                default: begin
                end
            endcase
        end
    endfunction

    always @(posedge aclk) begin
        blit_write_t want;
        if (!aresetn) begin
            base_q  = 32'h0;
            pitch_q = 16'h0;
            depth_q = DEPTH_8BPP;
            width_q = RESET_SCREEN_WIDTH;
            expected_writes.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FB_BASE:      base_q  = cfg_data;
                    CFG_LINE_PITCH:   pitch_q = cfg_data[15:0];
                    CFG_PIXEL_DEPTH:  depth_q = cfg_data[5:0];
                    CFG_SCREEN_WIDTH: width_q = cfg_data[11:0];
                    default: begin
                    end
                endcase
            end
            if (s_valid && s_ready)
                predict_writes();
            if (m_valid && m_ready) begin
                if (expected_writes.size() == 0) begin
                    $error("unexpected register write: reg_index %0d reg_value %h",
                           m_reg_index, m_reg_value);
                    errors++;
                end else begin
                    want = expected_writes.pop_front();
                    if (m_reg_index !== want.index) begin
                        $error("reg_index: expected %0d, got %0d", want.index, m_reg_index);
                        errors++;
                    end
                    if (m_reg_value !== want.value) begin
                        $error("reg_value: expected %h, got %h", want.value, m_reg_value);
                        errors++;
                    end
                    if (m_last !== want.last) begin
                        $error("last: expected %b, got %b", want.last, m_last);
                        errors++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %b, got %b", want.status, m_status);
                        errors++;
                    end
                end
            end
        end
        outstanding = expected_writes.size();
    end

endmodule

>>> tb/tb.sv
// Top of the blit command builder testbench: clock, reset, configuration phases,
// directed and random requests, output stalls and the verdict.
// Depends on bcb_pkg, blit_command_builder_top and blit_write_checker.
module tb;
    import bcb_pkg::*;

    localparam logic [1:0]  KIND_UNDEFINED   = 2'd3;
    localparam logic [3:0]  CFG_UNUSED_INDEX = 4'd7;
    localparam int          SETTLE_CYCLES    = 12;
    localparam int          NUM_PHASES       = 8;
    localparam int          ITEMS_PER_PHASE  = 11;
    localparam int unsigned CYCLE_LIMIT      = 200000;

    typedef struct packed {
        logic [1:0]            kind;
        logic [COORD_BITS-1:0] dx0, dy0, dx1, dy1;
        logic [COORD_BITS-1:0] sx0, sy0, sx1, sy1;
        logic [31:0]           fill;
    } blit_req_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [3:0]            cfg_index;
    logic [31:0]           cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [1:0]            s_kind;
    logic [COORD_BITS-1:0] s_dst_min_x, s_dst_min_y, s_dst_max_x, s_dst_max_y;
    logic [COORD_BITS-1:0] s_src_min_x, s_src_min_y, s_src_max_x, s_src_max_y;
    logic [31:0]           s_fill_value;
    logic                  m_valid;
    logic                  m_ready;
    logic [3:0]            m_reg_index;
    logic [31:0]           m_reg_value;
    logic                  m_last;
    logic                  m_status;

    int unsigned check_errors;
    int unsigned writes_pending;
    int unsigned cycle_count = 0;
    int          stall_left = 0;
    bit          idle_on;

    logic [11:0] known_widths [7] = '{12'd320, 12'd640, 12'd800, 12'd1024,
                                      12'd1152, 12'd1280, 12'd1600};

    blit_command_builder_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_dst_min_x(s_dst_min_x), .s_dst_min_y(s_dst_min_y),
        .s_dst_max_x(s_dst_max_x), .s_dst_max_y(s_dst_max_y),
        .s_src_min_x(s_src_min_x), .s_src_min_y(s_src_min_y),
        .s_src_max_x(s_src_max_x), .s_src_max_y(s_src_max_y),
        .s_fill_value(s_fill_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reg_index(m_reg_index), .m_reg_value(m_reg_value),
        .m_last(m_last), .m_status(m_status)
    );

    blit_write_checker u_write_check (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_dst_min_x(s_dst_min_x), .s_dst_min_y(s_dst_min_y),
        .s_dst_max_x(s_dst_max_x), .s_dst_max_y(s_dst_max_y),
        .s_src_min_x(s_src_min_x), .s_src_min_y(s_src_min_y),
        .s_src_max_x(s_src_max_x), .s_src_max_y(s_src_max_y),
        .s_fill_value(s_fill_value),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_reg_index(m_reg_index), .m_reg_value(m_reg_value),
        .m_last(m_last), .m_status(m_status),
        .errors(check_errors), .outstanding(writes_pending)
    );

    initial aclk = 1'b0;
    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side back-pressure: random stall bursts while idling is enabled.
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 7) - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    function automatic blit_req_t rect_req(
        input logic [1:0] kind,
        input logic [11:0] dx0, input logic [11:0] dy0,
        input logic [11:0] dx1, input logic [11:0] dy1,
        input logic [11:0] sx0, input logic [11:0] sy0,
        input logic [11:0] sx1, input logic [11:0] sy1,
        input logic [31:0] fill);
        blit_req_t r;
        r.kind = kind;
        r.dx0 = dx0; r.dy0 = dy0; r.dx1 = dx1; r.dy1 = dy1;
        r.sx0 = sx0; r.sy0 = sy0; r.sx1 = sx1; r.sy1 = sy1;
        r.fill = fill;
        return r;
    endfunction

    // Returns {min, max} of two random coordinates, so the edge pair is well formed.
    function automatic logic [23:0] ordered_span();
        logic [11:0] a, b;
        a = 12'($urandom_range(0, 4095));
        b = 12'($urandom_range(0, 4095));
        return (a <= b) ? {a, b} : {b, a};
    endfunction

    function automatic blit_req_t random_request();
        blit_req_t r;
        int pick;
        logic [11:0] shift_x, shift_y;
        pick = $urandom_range(0, 99);
        if (pick < 12)      r.kind = KIND_INIT;
        else if (pick < 47) r.kind = KIND_FILL;
        else if (pick < 92) r.kind = KIND_COPY;
        else                r.kind = KIND_UNDEFINED;
        r.fill = $urandom;
        if ($urandom_range(0, 9) == 0) begin
            // Unordered edges exercise the wrapping extent and direction choice.
            {r.dx0, r.dy0, r.dx1, r.dy1} = 48'({$urandom, $urandom});
            {r.sx0, r.sy0, r.sx1, r.sy1} = 48'({$urandom, $urandom});
        end else begin
            {r.dx0, r.dx1} = ordered_span();
            {r.dy0, r.dy1} = ordered_span();
            if ($urandom_range(0, 1) == 0) begin
                // Source close to the destination, so the rectangles overlap.
                shift_x = 12'($urandom_range(0, 16)) - 12'd8;
                shift_y = 12'($urandom_range(0, 16)) - 12'd8;
                r.sx0 = r.dx0 + shift_x;
                r.sx1 = r.dx1 + shift_x;
                r.sy0 = r.dy0 + shift_y;
                r.sy1 = r.dy1 + shift_y;
            end else begin
                {r.sx0, r.sx1} = ordered_span();
                {r.sy0, r.sy1} = ordered_span();
            end
        end
        return r;
    endfunction

    // Called at a falling edge; returns at the falling edge after the item is taken,
    // with s_valid still high.
    task automatic push_request(input blit_req_t r);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_kind       <= r.kind;
        s_dst_min_x  <= r.dx0;
        s_dst_min_y  <= r.dy0;
        s_dst_max_x  <= r.dx1;
        s_dst_max_y  <= r.dy1;
        s_src_min_x  <= r.sx0;
        s_src_min_y  <= r.sy0;
        s_src_max_x  <= r.sx1;
        s_src_max_y  <= r.sy1;
        s_fill_value <= r.fill;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic configure(input logic [31:0] base, input logic [31:0] pitch,
                             input logic [31:0] depth, input logic [31:0] width);
        write_reg(CFG_FB_BASE, base);
        write_reg(CFG_LINE_PITCH, pitch);
        write_reg(CFG_PIXEL_DEPTH, depth);
        write_reg(CFG_SCREEN_WIDTH, width);
    endtask

    // An unknown kind produces no write, so allow the pipeline to empty after the
    // last expected write before touching the registers.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (writes_pending != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [31:0] base, pitch, depth, width;
        int pick;
        aresetn      = 1'b0;
        idle_on      = 1'b1;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_FB_BASE;
        cfg_data     = 32'h0;
        s_valid      = 1'b0;
        s_kind       = KIND_INIT;
        s_dst_min_x  = '0;
        s_dst_min_y  = '0;
        s_dst_max_x  = '0;
        s_dst_max_y  = '0;
        s_src_min_x  = '0;
        s_src_min_y  = '0;
        s_src_max_x  = '0;
        s_src_max_y  = '0;
        s_fill_value = 32'h0;
        m_ready      = 1'b0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Register defaults straight out of reset.
        push_request(rect_req(KIND_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_FILL, 5, 7, 100, 50, 0, 0, 0, 0, 32'h1234_5678));
        push_request(rect_req(KIND_COPY, 30, 30, 60, 60, 20, 20, 50, 50, 32'h0));
        wait_idle();

        configure(32'h1000_0000, 32'd1280, 32'd8, 32'd1024);
        push_request(rect_req(KIND_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_FILL, 0, 0, 4095, 4095, 0, 0, 0, 0, 32'hffff_ffff));
        push_request(rect_req(KIND_FILL, 4095, 4095, 0, 0, 4095, 4095, 4095, 4095, 32'h0));
        push_request(rect_req(KIND_COPY, 10, 10, 110, 60, 10, 20, 110, 70, 32'h0));
        push_request(rect_req(KIND_COPY, 5, 30, 50, 40, 9, 30, 54, 40, 32'h0));
        push_request(rect_req(KIND_COPY, 20, 20, 40, 40, 20, 20, 40, 40, 32'h0));
        push_request(rect_req(KIND_COPY, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_UNDEFINED, 1, 2, 3, 4, 5, 6, 7, 8, 32'hdead_beef));
        wait_idle();

        // All-ones base and pitch; junk above the depth and pitch fields.
        configure(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffd0, 32'h0000_0fff);
        push_request(rect_req(KIND_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_FILL, 4095, 4095, 4095, 4095, 0, 0, 0, 0, 32'ha5a5_5a5a));
        push_request(rect_req(KIND_COPY, 100, 200, 300, 400, 100, 100, 300, 300, 32'h0));
        push_request(rect_req(KIND_COPY, 0, 0, 4095, 4095, 4095, 4095, 0, 0, 32'h0));
        push_request(rect_req(KIND_COPY, 4095, 4095, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_UNDEFINED, 4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095,
                              32'hffff_ffff));
        wait_idle();

        // Unsupported depth: every kind answers with a single status write.
        configure(32'h0, 32'd1, 32'd0, 32'd1600);
        push_request(rect_req(KIND_INIT, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        push_request(rect_req(KIND_FILL, 1, 1, 9, 9, 0, 0, 0, 0, 32'h5555_aaaa));
        push_request(rect_req(KIND_COPY, 4, 4, 8, 8, 0, 0, 4, 4, 32'h0));
        push_request(rect_req(KIND_UNDEFINED, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0));
        wait_idle();

        configure(32'h8000_0000, 32'd640, 32'd32, 32'd320);
        write_reg(CFG_UNUSED_INDEX, 32'h0000_0008);
        push_request(rect_req(KIND_FILL, 2, 3, 4, 5, 0, 0, 0, 0, 32'h0f0f_0f0f));
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            idle_on = (phase < NUM_PHASES - 2);
            pick = $urandom_range(0, 3);
            base = (pick == 0) ? 32'h0 : (pick == 1) ? 32'hffff_ffff : $urandom;
            pick = $urandom_range(0, 3);
            pitch = {16'($urandom), (pick == 0) ? 16'h0 : (pick == 1) ? 16'hffff
                                                         : 16'($urandom)};
            pick = $urandom_range(0, 99);
            depth = {26'($urandom), (pick < 45) ? DEPTH_8BPP : (pick < 90) ? DEPTH_16BPP
                                                            : 6'($urandom)};
            width = {20'($urandom), ($urandom_range(0, 3) != 0)
                                    ? known_widths[$urandom_range(0, 6)] : 12'($urandom)};
            configure(base, pitch, depth, width);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                push_request(random_request());
            wait_idle();
        end

        if (check_errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/bcb_pkg.sv
design/bcb_addr.sv
design/bcb_emit.sv
design/blit_command_builder_top.sv
tb/blit_write_checker.sv
tb/tb.sv
